>>> hdl/ddcr_pkg.sv
// Package: shared types, codes and constants of the dual disk controller register block
`timescale 1ns / 1ps

package ddcr_pkg;

  // action codes carried in the input tuser
  typedef enum logic [2:0] {
    ACT_XCHG      = 3'd0,
    ACT_CTRL      = 3'd1,
    ACT_RD_STAT   = 3'd2,
    ACT_RD_ERR    = 3'd3,
    ACT_XFER_DONE = 3'd4
  } action_e;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_ATTACHED = 2'd0,
    CFG_READONLY = 2'd1,
    CFG_DISABLED = 2'd2
  } cfg_idx_e;

  // control command sub-codes (low six bits)
  localparam logic [5:0] SUB_FORMAT   = 6'o05;
  localparam logic [5:0] SUB_RDHDR_A  = 6'o07;
  localparam logic [5:0] SUB_RDHDR_B  = 6'o47;
  localparam logic [5:0] SUB_STAT_CLR = 6'o10;
  localparam logic [5:0] SUB_STAT_Q0  = 6'o11;
  localparam logic [5:0] SUB_STAT_Q1  = 6'o31;
  localparam logic [5:0] SUB_NOP0     = 6'o00;
  localparam logic [5:0] SUB_NOP1     = 6'o01;
  localparam logic [5:0] SUB_NOP2     = 6'o02;
  localparam logic [5:0] SUB_NOP3     = 6'o03;
  localparam logic [5:0] SUB_NOP4     = 6'o04;
  localparam logic [5:0] SUB_NOP6     = 6'o06;
  localparam logic [5:0] SUB_NOP43    = 6'o43;
  localparam logic [5:0] SUB_NOP44    = 6'o44;
  localparam logic [5:0] SUB_NOP50    = 6'o50;

  // exchange word fields
  localparam int unsigned XW_SYSDATA_BIT  = 20;
  localparam int unsigned XW_PAGEMODE_BIT = 18;
  localparam int unsigned XW_READ_BIT     = 17;
  localparam int unsigned XW_HALFPG_BIT   = 11;

  // control command bits
  localparam int unsigned CC_XFER_BIT  = 11;
  localparam int unsigned CC_SEL_BIT   = 10;
  localparam int unsigned CC_READY_BIT = 8;

  // status words loaded by the status queries
  localparam logic [31:0] STAT_GOOD    = 32'o014000400;
  localparam logic [11:0] STAT_WORD_Q0 = STAT_GOOD[11:0];
  localparam logic [11:0] STAT_WORD_Q1 = STAT_GOOD[23:12];

  // channel widths
  localparam int unsigned CMD_W       = 28;
  localparam int unsigned ACT_W       = 3;
  localparam int unsigned IN_TDATA_W  = 32;
  localparam int unsigned OUT_TDATA_W = 56;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned CFG_IDX_W   = 2;

  // per-controller register set
  typedef struct packed {
    logic [CMD_W-1:0] xw;
    logic [3:0]       drive;
    logic [9:0]       zone;
    logic             half;
    logic [19:0]      maddr;
    logic             fmt;
    logic [11:0]      status;
  } ctlr_regs_t;

  // architectural state of both controllers
  typedef struct packed {
    ctlr_regs_t [1:0] ctl;
    logic [1:0]       err;
    logic [1:0]       rdy;
  } regs_t;

  // configuration registers
  typedef struct packed {
    logic [15:0] attached;
    logic [15:0] readonly;
    logic        disabled;
  } cfg_t;

  // one input word
  typedef struct packed {
    action_e          action;
    logic             failed;
    logic [CMD_W-1:0] cmd;
    logic             ctlr;
  } item_t;

  // one result word, packed in tdata order (read_data lowest)
  typedef struct packed {
    logic [19:0] mem_addr;
    logic        half;
    logic [9:0]  zone;
    logic [3:0]  drive;
    logic        sysdata_only;
    logic        format;
    logic        page_mode;
    logic        rd;
    logic        start;
    logic [1:0]  ready_flags;
    logic [11:0] read_data;
  } result_t;

endpackage

>>> hdl/dual_disk_controller_command_regs.sv
// Top level: register side of two disk controllers with input and result registers
`timescale 1ns / 1ps

// Register side of two eight-drive disk controllers.
// Input stream: s_axis_tuser carries the action code, s_axis_tdata the
// controller, command bits and transfer-failed flag. Every input word gives
// exactly one result word on the m_axis stream: read data, the ready flags
// after the word, and a transfer start descriptor when the word launches one.
// Configuration (attached drives, read-only drives, subsystem disable) is
// written through cfg_we_i / cfg_idx_i / cfg_data_i; the user must do so only
// while no word is in flight, as the block does not enforce it. A taken word
// sits in the input register, is decoded combinationally, and its result is
// held in the result register on m_axis. Throughput: one word per cycle while
// the receiver takes results; each word reads and updates the controller
// registers combinationally, so the next word sees them. When the receiver
// stalls, the result register holds; the input register still takes one
// more word, after which s_axis_tready drops until a result is taken.
// Reset clears all controller registers, error and ready bits, and the
// configuration; both streams come up empty.
module dual_disk_controller_command_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [ddcr_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // ctlr, cmd[27:0], transfer_failed
  input  logic [ddcr_pkg::ACT_W-1:0]          s_axis_tuser,  // action
  // result stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // read_data[11:0], ready_flags[1:0], start_transfer, xfer_read, xfer_page_mode,
  // xfer_format, xfer_sysdata_only, xfer_drive[3:0], xfer_zone[9:0], xfer_half,
  // xfer_mem_addr[19:0]
  output logic [ddcr_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  // configuration write port
  input  logic                                cfg_we_i,
  input  logic [ddcr_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [ddcr_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import ddcr_pkg::*;

  logic    in_vld_q;
  item_t   in_q;
  logic    out_vld_q;
  result_t out_q;
  regs_t   regs_q;
  regs_t   regs_d;
  cfg_t    cfg_q;
  result_t res_d;
  logic    exec_fire;
  logic    in_take;

  // handshake
  assign exec_fire     = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || exec_fire;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q.action <= action_e'(s_axis_tuser);
      in_q.ctlr   <= s_axis_tdata[0];
      in_q.cmd    <= s_axis_tdata[CMD_W:1];
      in_q.failed <= s_axis_tdata[CMD_W+1];
    end
  end

  // command execution
  ddcr_exec u_exec (
    .item_i (in_q),
    .regs_i (regs_q),
    .cfg_i  (cfg_q),
    .regs_o (regs_d),
    .res_o  (res_d)
  );

  // controller registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q <= '0;
    end else if (exec_fire) begin
      regs_q <= regs_d;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ATTACHED: cfg_q.attached <= cfg_data_i[15:0];
        CFG_READONLY: cfg_q.readonly <= cfg_data_i[15:0];
        CFG_DISABLED: cfg_q.disabled <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (exec_fire) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_fire) begin
      out_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {(OUT_TDATA_W - $bits(result_t))'(0), out_q};

  // checks
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (in_vld_q && out_vld_q && !m_axis_tready))
    else $error("input stalled with room in the pipeline");

  a_no_start_when_disabled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exec_fire && res_d.start) |-> !cfg_q.disabled)
    else $error("transfer launched while subsystem disabled");

  a_idle_descriptor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exec_fire && !res_d.start) |-> (res_d.mem_addr == '0 && res_d.drive == '0 &&
                                      res_d.zone == '0 && !res_d.rd))
    else $error("descriptor fields set without a transfer start");

  a_failed_sets_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exec_fire && in_q.action == ACT_XFER_DONE && in_q.failed)
      |=> regs_q.err[$past(in_q.ctlr)] && regs_q.rdy[$past(in_q.ctlr)])
    else $error("failed transfer done did not set error and ready");

endmodule

>>> hdl/ddcr_exec.sv
// Combinational command execution: next register state and result word for one item
`timescale 1ns / 1ps

module ddcr_exec (
  input  ddcr_pkg::item_t   item_i,
  input  ddcr_pkg::regs_t   regs_i,
  input  ddcr_pkg::cfg_t    cfg_i,
  output ddcr_pkg::regs_t   regs_o,
  output ddcr_pkg::result_t res_o
);
  import ddcr_pkg::*;

  ctlr_regs_t  cs;
  ctlr_regs_t  cs_d;
  logic [1:0]  cbit;
  logic        att_old;
  logic        ro_old;
  logic        ok_old;
  logic        sel_found;
  logic [2:0]  sel_idx;
  logic [3:0]  sel_drive;
  logic [19:0] xw_addr;
  logic        emit;
  logic        emit_rd;

  // address derived from an exchange word
  always_comb begin
    xw_addr = {1'b0, item_i.cmd[26:23], item_i.cmd[16:12], 10'd0};
    if (!item_i.cmd[XW_PAGEMODE_BIT]) begin
      xw_addr[9] = item_i.cmd[XW_HALFPG_BIT];
    end
  end

  // drive selection priority encoder, bit 7 first
  always_comb begin
    sel_found = 1'b0;
    sel_idx   = 3'd0;
    for (int k = 0; k < 8; k++) begin
      if (item_i.cmd[k]) begin
        sel_found = 1'b1;
        sel_idx   = 3'(k);
      end
    end
    sel_drive = {item_i.ctlr, sel_idx};
  end

  assign cs      = regs_i.ctl[item_i.ctlr];
  assign cbit    = item_i.ctlr ? 2'b10 : 2'b01;
  assign att_old = cfg_i.attached[cs.drive];
  assign ro_old  = cfg_i.readonly[cs.drive];
  assign ok_old  = !cfg_i.disabled && att_old;

  // command decode and register update
  always_comb begin
    regs_o  = regs_i;
    cs_d    = cs;
    emit    = 1'b0;
    emit_rd = 1'b0;
    res_o   = '0;

    unique case (item_i.action)
      ACT_XCHG: begin
        cs_d.xw    = item_i.cmd;
        cs_d.maddr = xw_addr;
        cs_d.fmt   = 1'b0;
        regs_o.err = regs_i.err & ~cbit;
        regs_o.rdy = regs_i.rdy & ~cbit;
      end
      ACT_CTRL: begin
        if (item_i.cmd[CC_XFER_BIT]) begin
          if (!ok_old) begin
            regs_o.err = regs_i.err | cbit;
          end else begin
            cs_d.zone  = item_i.cmd[10:1];
            cs_d.half  = item_i.cmd[0];
            regs_o.err = regs_i.err & ~cbit;
            if (cs.xw[XW_READ_BIT]) begin
              emit    = 1'b1;
              emit_rd = 1'b1;
            end else if (ro_old) begin
              regs_o.err = regs_i.err | cbit;
            end else begin
              emit = 1'b1;
            end
          end
        end else if (item_i.cmd[CC_SEL_BIT]) begin
          if (sel_found) begin
            cs_d.drive = sel_drive;
            if (cfg_i.disabled || !cfg_i.attached[sel_drive]) begin
              regs_o.err = regs_i.err | cbit;
            end
          end
        end else if (item_i.cmd[CC_READY_BIT]) begin
          regs_o.rdy = regs_i.rdy | cbit;
        end else begin
          unique case (item_i.cmd[5:0]) inside
            SUB_NOP0, SUB_NOP1, SUB_NOP2, SUB_NOP3, SUB_NOP4, SUB_NOP6,
            SUB_NOP43, SUB_NOP44, SUB_NOP50: begin
            end
            SUB_FORMAT: begin
              cs_d.fmt = 1'b1;
            end
            SUB_RDHDR_A, SUB_RDHDR_B: begin
              cs_d.fmt = 1'b1;
              if (ok_old) begin
                regs_o.err = regs_i.err & ~cbit;
                emit       = 1'b1;
                emit_rd    = 1'b1;
              end else begin
                regs_o.err = regs_i.err | cbit;
              end
            end
            SUB_STAT_CLR: begin
              cs_d.status = '0;
            end
            SUB_STAT_Q0: begin
              cs_d.status = att_old ? STAT_WORD_Q0 : '0;
            end
            SUB_STAT_Q1: begin
              cs_d.status = att_old ? STAT_WORD_Q1 : '0;
            end
            default: begin
              regs_o.rdy = regs_i.rdy | cbit;
            end
          endcase
        end
      end
      ACT_RD_STAT: begin
        res_o.read_data = cs.status;
      end
      ACT_RD_ERR: begin
        res_o.read_data = {7'd0, regs_i.err[0], regs_i.err[1], 3'd0};
      end
      ACT_XFER_DONE: begin
        regs_o.rdy = regs_i.rdy | cbit;
        if (item_i.failed) begin
          regs_o.err = regs_i.err | cbit;
        end
      end
      default: begin
      end
    endcase

    regs_o.ctl[item_i.ctlr] = cs_d;

    // transfer descriptor from the updated controller registers
    if (emit) begin
      res_o.start        = 1'b1;
      res_o.rd           = emit_rd;
      res_o.page_mode    = cs_d.xw[XW_PAGEMODE_BIT];
      res_o.format       = cs_d.fmt;
      res_o.sysdata_only = emit_rd && cs_d.xw[XW_SYSDATA_BIT];
      res_o.drive        = cs_d.drive;
      res_o.zone         = cs_d.zone;
      res_o.half         = cs_d.half;
      res_o.mem_addr     = cs_d.maddr;
    end
    res_o.ready_flags = regs_o.rdy;
  end

endmodule
